// ----- rtl/cic_charge_deposit_2d_core_macros.svh -----
// Assertion macros for the cloud-in-cell charge deposition core.
// Used by cic_charge_deposit_2d_core; needs a clock clk and reset rst in scope.
`ifndef CIC_CHARGE_DEPOSIT_2D_CORE_MACROS_SVH
`define CIC_CHARGE_DEPOSIT_2D_CORE_MACROS_SVH

// Clocked check, off while reset is high.
`define CCD2D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds.
`define CCD2D_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/ccd2d_pkg.sv -----
// Shared constants, codes and types of the charge deposition core.
// No dependencies.
package ccd2d_pkg;

  localparam int MAX_CELLS_X = 64;
  localparam int MAX_CELLS_Y = 64;
  localparam int GRID_DEPTH  = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int NX_W        = $clog2(MAX_CELLS_X + 1);
  localparam int NY_W        = $clog2(MAX_CELLS_Y + 1);
  localparam int XI_W        = $clog2(MAX_CELLS_X);

  localparam logic [1:0] CMD_DEPOSIT    = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  localparam logic [2:0] REG_CELLS_X = 3'd0;
  localparam logic [2:0] REG_CELLS_Y = 3'd1;
  localparam logic [2:0] REG_INV_X   = 3'd2;
  localparam logic [2:0] REG_INV_Y   = 3'd3;
  localparam logic [2:0] REG_CHARGE  = 3'd4;

  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef struct packed {
    logic w_en;  // form weight, latch charge magnitude
    logic m_en;  // charge times weight
    logic r_en;  // round and apply sign
  } accum_ctl_t;

endpackage

// ----- rtl/ccd2d_ram.sv -----
// Generic simple dual-port RAM, registered read.
// No dependencies.
module ccd2d_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ccd2d_scale.sv -----
// Position scaling: pos times reciprocal cell width, split into index and fraction.
// No dependencies; no package use.
module ccd2d_scale (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [23:0] inv_x,
  input  logic [23:0] inv_y,
  output logic [23:0] ix,
  output logic [23:0] iy,
  output logic [15:0] fx,
  output logic [15:0] fy
);

  logic [55:0] sx;
  logic [55:0] sy;

  always_ff @(posedge clk) begin
    if (load) begin
      sx <= 56'(pos_x) * 56'(inv_x);
      sy <= 56'(pos_y) * 56'(inv_y);
    end
  end

  assign ix = sx[55:32];
  assign iy = sy[55:32];
  assign fx = sx[31:16];
  assign fy = sy[31:16];

endmodule

// ----- rtl/ccd2d_accum.sv -----
// Contribution pipeline: weight, charge product, rounding, saturating cell sum.
// Depends on ccd2d_pkg (accum_ctl_t).
module ccd2d_accum (
  input  logic                  clk,
  input  ccd2d_pkg::accum_ctl_t ctl,
  input  logic [16:0]           wa,
  input  logic [16:0]           wb,
  input  logic [31:0]           charge,
  input  logic [31:0]           old,
  output logic [31:0]           sum
);

  logic [32:0] weight;
  logic [31:0] mag;
  logic        neg;
  logic [64:0] prod;
  logic [33:0] delta;
  logic [64:0] rnd;
  logic [34:0] total;

  always_ff @(posedge clk) begin
    if (ctl.w_en) begin
      weight <= 33'(34'(wa) * 34'(wb));
      neg    <= charge[31];
      mag    <= charge[31] ? (~charge + 32'd1) : charge;
    end
    if (ctl.m_en) prod <= 65'(mag) * 65'(weight);
    if (ctl.r_en) delta <= neg ? (34'd0 - 34'(rnd[64:32])) : 34'(rnd[64:32]);
  end

  // round to nearest, ties away from zero on the magnitude
  assign rnd   = prod + 65'h0_8000_0000;
  assign total = 35'(signed'(old)) + 35'(signed'(delta));

  always_comb begin
    if (!total[34] && total[33:31] != 3'b000) sum = 32'h7FFF_FFFF;
    else if (total[34] && total[33:31] != 3'b111) sum = 32'h8000_0000;
    else sum = total[31:0];
  end

endmodule

// ----- rtl/cic_charge_deposit_2d_core.sv -----
// Channel  | dir | signals                         | contents
// s        | in  | s_tvalid s_tready s_tdata s_tuser | command and particle or cell address
// m        | out | m_tvalid m_tready m_tdata       | cell charge and echoed address
// cfg      | in  | cfg_we cfg_addr cfg_wdata       | register writes
// A deposit holds off new input from acceptance through S_SCALE and S_CHECK (scale
// and locate), then S_WMUL, S_CMUL, S_RND and S_ADD for each neighbour (weight and
// grid read, product, rounding, write-back into the single grid RAM).
// A read waits in S_RDW while the output register is full and untaken.
// After reset a clearing pass zeroes every grid cell; no transfer is
// accepted meanwhile, configuration writes are taken.
// Depends on ccd2d_pkg, ccd2d_ram, ccd2d_scale, ccd2d_accum and the macro header.
`include "cic_charge_deposit_2d_core_macros.svh"

module cic_charge_deposit_2d_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // pos_x[31:0], pos_y[63:32], cell_index[75:64], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cell_charge[31:0], cell_echo[43:32], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = ccd2d_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCALE, S_CHECK, S_WMUL, S_CMUL, S_RND, S_ADD, S_RDW
  } state_t;

  state_t state;

  logic [6:0]  grid_cells_x;
  logic [6:0]  grid_cells_y;
  logic [23:0] inv_cell_x;
  logic [23:0] inv_cell_y;
  logic [31:0] particle_charge;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] base;
  logic [AW-1:0] ny_step;
  logic [15:0]   fx_r;
  logic [15:0]   fy_r;
  logic [3:0]    mask;
  logic [1:0]    k;
  logic [11:0]   rd_addr;
  logic          rd_clear;
  logic          rd_ok;
  logic [31:0]   out_charge;
  logic [11:0]   out_echo;

  logic          accept;
  logic [1:0]    cmd;
  logic [11:0]   cell_index;
  logic [23:0]   ix;
  logic [23:0]   iy;
  logic [15:0]   fx;
  logic [15:0]   fy;
  logic [ccd2d_pkg::NX_W-1:0] nx;
  logic [ccd2d_pkg::NY_W-1:0] ny;
  logic          in_grid;
  logic          has_right;
  logic          has_up;
  logic [AW-1:0] addr_k;
  logic [16:0]   wa;
  logic [16:0]   wb;
  logic          out_free;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [31:0]   sum;
  ccd2d_pkg::accum_ctl_t ctl;

  assign cmd        = s_tuser;
  assign cell_index = s_tdata[75:64];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign m_tdata    = {4'd0, out_echo, out_charge};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cells_x    <= 7'd64;
      grid_cells_y    <= 7'd64;
      inv_cell_x      <= 24'd65536;
      inv_cell_y      <= 24'd65536;
      particle_charge <= 32'd16777216;
    end else if (cfg_we) begin
      case (cfg_addr)
        ccd2d_pkg::REG_CELLS_X: grid_cells_x    <= cfg_wdata[6:0];
        ccd2d_pkg::REG_CELLS_Y: grid_cells_y    <= cfg_wdata[6:0];
        ccd2d_pkg::REG_INV_X:   inv_cell_x      <= cfg_wdata[23:0];
        ccd2d_pkg::REG_INV_Y:   inv_cell_y      <= cfg_wdata[23:0];
        ccd2d_pkg::REG_CHARGE:  particle_charge <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ccd2d_scale u_scale (
    .clk   (clk),
    .load  (accept && cmd == ccd2d_pkg::CMD_DEPOSIT),
    .pos_x (s_tdata[31:0]),
    .pos_y (s_tdata[63:32]),
    .inv_x (inv_cell_x),
    .inv_y (inv_cell_y),
    .ix    (ix),
    .iy    (iy),
    .fx    (fx),
    .fy    (fy)
  );

  // clamp counts to the store dimensions
  assign nx = (32'(grid_cells_x) > ccd2d_pkg::MAX_CELLS_X) ?
              ccd2d_pkg::NX_W'(ccd2d_pkg::MAX_CELLS_X) : ccd2d_pkg::NX_W'(grid_cells_x);
  assign ny = (32'(grid_cells_y) > ccd2d_pkg::MAX_CELLS_Y) ?
              ccd2d_pkg::NY_W'(ccd2d_pkg::MAX_CELLS_Y) : ccd2d_pkg::NY_W'(grid_cells_y);
  assign in_grid   = (32'(ix) < 32'(nx)) && (32'(iy) < 32'(ny));
  assign has_right = (32'(ix) + 32'd1) < 32'(nx);
  assign has_up    = (32'(iy) + 32'd1) < 32'(ny);

  always_comb begin
    case (k)
      2'd0:    begin addr_k = base;                  wa = ccd2d_pkg::FRAC_ONE - 17'(fx_r);
                     wb = ccd2d_pkg::FRAC_ONE - 17'(fy_r); end
      2'd1:    begin addr_k = base + AW'(1);         wa = ccd2d_pkg::FRAC_ONE - 17'(fx_r);
                     wb = 17'(fy_r); end
      2'd2:    begin addr_k = base + ny_step;        wa = 17'(fx_r);
                     wb = ccd2d_pkg::FRAC_ONE - 17'(fy_r); end
      default: begin addr_k = base + ny_step + AW'(1); wa = 17'(fx_r); wb = 17'(fy_r); end
    endcase
  end

  assign ctl.w_en = (state == S_WMUL);
  assign ctl.m_en = (state == S_CMUL);
  assign ctl.r_en = (state == S_RND);

  ccd2d_accum u_accum (
    .clk    (clk),
    .ctl    (ctl),
    .wa     (wa),
    .wb     (wb),
    .charge (particle_charge),
    .old    (ram_rdata),
    .sum    (sum)
  );

  // grid RAM port use
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_k;
    ram_wdata = sum;
    ram_re    = 1'b0;
    ram_raddr = addr_k;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 32'd0;
      end
      S_IDLE: begin
        ram_re    = accept && (cmd == ccd2d_pkg::CMD_READ || cmd == ccd2d_pkg::CMD_READ_CLEAR);
        ram_raddr = AW'(cell_index);
      end
      S_WMUL: ram_re = 1'b1;
      S_ADD:  ram_we = mask[k];
      S_RDW: begin
        ram_we    = out_free && rd_clear && rd_ok;
        ram_waddr = AW'(rd_addr);
        ram_wdata = 32'd0;
      end
      default: ;
    endcase
  end

  ccd2d_ram #(.DEPTH(ccd2d_pkg::GRID_DEPTH), .WIDTH(32)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      k        <= 2'd0;
    end else begin
      // drop the taken result unless a new one is loaded in this cycle
      if (m_tvalid && m_tready && !(state == S_RDW && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(ccd2d_pkg::GRID_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            rd_addr  <= cell_index;
            rd_clear <= (cmd == ccd2d_pkg::CMD_READ_CLEAR);
            rd_ok    <= 32'(cell_index) < ccd2d_pkg::GRID_DEPTH;
            unique case (cmd) inside
              ccd2d_pkg::CMD_DEPOSIT: state <= S_SCALE;
              ccd2d_pkg::CMD_READ, ccd2d_pkg::CMD_READ_CLEAR: state <= S_RDW;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCALE: state <= S_CHECK;
        S_CHECK: begin
          base    <= AW'(iy) + AW'(ny) * AW'(ix[ccd2d_pkg::XI_W-1:0]);
          ny_step <= AW'(ny);
          fx_r    <= fx;
          fy_r    <= fy;
          mask    <= {has_right && has_up, has_right, has_up, 1'b1};
          k       <= 2'd0;
          state   <= in_grid ? S_WMUL : S_IDLE;
        end
        S_WMUL: state <= S_CMUL;
        S_CMUL: state <= S_RND;
        S_RND:  state <= S_ADD;
        S_ADD: begin
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? S_IDLE : S_WMUL;
        end
        S_RDW: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_charge <= rd_ok ? ram_rdata : 32'd0;
            out_echo   <= rd_addr;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CCD2D_NEVER(a_port_clash, ram_we && ram_re, "grid RAM read and write in one cycle")
  `CCD2D_ASSERT(a_out_source, $rose(m_tvalid) |-> $past(state == S_RDW),
                "result not from read")
  `CCD2D_ASSERT(a_rmw_addr,
                (state == S_ADD && ram_we) |-> ram_waddr == $past(ram_raddr, 3),
                "update address differs from read address")
  `CCD2D_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata),
                "pending result lost")

endmodule
